[design/ftnr_pkg.sv]
package ftnr_pkg;

	// Field widths fixed by the item format
	localparam int INDEX_BITS    = 12;
	localparam int NUMBER_BITS   = 12;
	localparam int RANK_OUT_BITS = 8;
	localparam int NEXT_BITS     = 13;

	// Generation tag kept beside each map entry; tag zero marks an empty entry
	localparam int EPOCH_BITS = 4;

	// Defaults for the top-level parameters
	localparam int NODE_COUNT_DEF = 4096;
	localparam int RANK_BITS_DEF  = 8;

	typedef enum logic {
		ACT_REF   = 1'b0,
		ACT_CLEAR = 1'b1
	} action_t;

endpackage

[design/ftnr_req_if.sv]
interface ftnr_req_if;
	logic                               valid;
	logic                               ready;
	ftnr_pkg::action_t                  action;
	logic [ftnr_pkg::INDEX_BITS-1:0]    node_index;

	modport source (output valid, output action, output node_index, input ready);
	modport sink   (input valid, input action, input node_index, output ready);
endinterface

[design/ftnr_rsp_if.sv]
interface ftnr_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [ftnr_pkg::NUMBER_BITS-1:0]    new_number;
	logic [ftnr_pkg::RANK_OUT_BITS-1:0]  occurrence_rank;
	logic                                newly_assigned;

	modport source (output valid, output new_number, output occurrence_rank,
		output newly_assigned, input ready);
	modport sink   (input valid, input new_number, input occurrence_rank,
		input newly_assigned, output ready);
endinterface

[design/first_touch_node_renumbering_top.sv]
// First-touch node renumbering. Each request item carries an old node index
// (or a clear action); the block answers every item with one response item:
// the node's new number in first-touch order, how many times the node was
// referenced before (saturating at 2^RANK_BITS-1, low 8 bits shown), and a
// flag that marks the reference that assigned the number. A clear action
// answers with all zeros and empties the map, the ranks and the counter; an
// index at or above NODE_COUNT answers with zeros and changes nothing. The
// map lives in one single-port-write RAM of NODE_COUNT words, each word
// holding a 4-bit generation tag, the new number and the rank. Items stream
// at one per cycle unless the response side stalls, a pass runs or a clear
// that wraps the tag waits in stage 1: the RAM is read as an item is
// accepted, and the entry is updated and written back from stage 1, with the
// last write forwarded to a following reference to the same node. A clear
// only bumps the generation tag. After reset, and after every fifteenth
// clear when the tag wraps, a clearing pass writes every RAM word to the
// empty tag; no request item is taken during the pass.
module first_touch_node_renumbering_top #(
	parameter int NODE_COUNT = ftnr_pkg::NODE_COUNT_DEF,
	parameter int RANK_BITS  = ftnr_pkg::RANK_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ftnr_req_if.sink  req,
	ftnr_rsp_if.source rsp
);

	import ftnr_pkg::*;

	localparam int AW     = $clog2(NODE_COUNT);
	localparam int WORD_W = EPOCH_BITS + NUMBER_BITS + RANK_BITS;

	localparam logic [EPOCH_BITS-1:0] EPOCH_MAX   = {EPOCH_BITS{1'b1}};
	localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
	localparam logic [RANK_BITS-1:0]  RANK_MAX    = {RANK_BITS{1'b1}};
	localparam logic [NEXT_BITS-1:0]  NEXT_MAX    = {NEXT_BITS{1'b1}};
	localparam logic [AW-1:0]         LAST_ADDR   = AW'(NODE_COUNT - 1);

	// Control state
	logic                  pass_q;       // clearing pass running
	logic [AW-1:0]         pass_cnt_q;
	logic [EPOCH_BITS-1:0] epoch_q;
	logic [NEXT_BITS-1:0]  next_q;
	logic                  fwd_valid_q;
	logic [AW-1:0]         fwd_addr_q;
	logic [WORD_W-1:0]     fwd_data_q;

	// Stage 1: RAM read data arrives
	logic                  valid_s1;
	action_t               action_s1;
	logic                  in_range_s1;
	logic [AW-1:0]         addr_s1;

	// Output register
	logic                   out_valid_q;
	logic [NUMBER_BITS-1:0] out_number_q;
	logic [RANK_BITS-1:0]   out_rank_q;
	logic                   out_fresh_q;

	// RAM ports
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic              ram_re;
	logic [WORD_W-1:0] ram_rdata;

	// Combinational
	logic                   advance;
	logic                   wrap_hold;
	logic                   accept;
	logic [WORD_W-1:0]      entry;
	logic [EPOCH_BITS-1:0]  entry_epoch;
	logic [NUMBER_BITS-1:0] entry_number;
	logic [RANK_BITS-1:0]   entry_rank;
	logic                   seen;
	logic                   do_ref;
	logic                   do_clear;
	logic [NUMBER_BITS-1:0] res_number;
	logic [RANK_BITS-1:0]   res_rank;
	logic                   res_fresh;
	logic [RANK_BITS-1:0]   rank_upd;

	ftnr_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NODE_COUNT)
	) u_map_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (AW'(req.node_index)),
		.rdata (ram_rdata)
	);

	// Move stage 1 forward whenever the output register is free or drains
	assign advance   = !out_valid_q || rsp.ready;
	// Hold intake while a clear that wraps the tag sits in stage 1
	assign wrap_hold = valid_s1 && (action_s1 == ACT_CLEAR) && (epoch_q == EPOCH_MAX);
	assign req.ready = advance && !pass_q && !wrap_hold;
	assign accept    = req.valid && req.ready;
	assign ram_re    = accept;

	// Take the last write if it hit this entry; RAM data may be stale
	assign entry = (fwd_valid_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : ram_rdata;
	assign entry_epoch  = entry[WORD_W-1 -: EPOCH_BITS];
	assign entry_number = entry[RANK_BITS +: NUMBER_BITS];
	assign entry_rank   = entry[RANK_BITS-1:0];
	assign seen         = (entry_epoch == epoch_q);

	assign do_ref   = valid_s1 && advance && (action_s1 == ACT_REF) && in_range_s1;
	assign do_clear = valid_s1 && advance && (action_s1 == ACT_CLEAR);

	always_comb begin
		res_number = '0;
		res_rank   = '0;
		res_fresh  = 1'b0;
		if ((action_s1 == ACT_REF) && in_range_s1) begin
			if (seen) begin
				res_number = entry_number;
				res_rank   = entry_rank;
			end else begin
				res_number = next_q[NUMBER_BITS-1:0];
				res_fresh  = 1'b1;
			end
		end
		// Saturate the rank at its top value
		rank_upd = (res_rank == RANK_MAX) ? res_rank : res_rank + RANK_BITS'(1);
	end

	// Write port: clearing pass or write-back of stage 1
	always_comb begin
		ram_we    = pass_q || do_ref;
		ram_waddr = pass_q ? pass_cnt_q : addr_s1;
		ram_wdata = pass_q ? '0 : {epoch_q, res_number, rank_upd};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q      <= 1'b1;
			pass_cnt_q  <= '0;
			epoch_q     <= EPOCH_FIRST;
			next_q      <= '0;
			fwd_valid_q <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Sweep the RAM to the empty tag
			if (pass_q) begin
				pass_cnt_q <= pass_cnt_q + AW'(1);
				if (pass_cnt_q == LAST_ADDR) begin
					pass_q <= 1'b0;
				end
			end

			if (do_clear) begin
				next_q <= '0;
				if (epoch_q == EPOCH_MAX) begin
					// Tag wraps: start a pass and drop the forward entry
					epoch_q     <= EPOCH_FIRST;
					pass_q      <= 1'b1;
					pass_cnt_q  <= '0;
					fwd_valid_q <= 1'b0;
				end else begin
					epoch_q <= epoch_q + EPOCH_BITS'(1);
				end
			end

			if (do_ref) begin
				fwd_valid_q <= 1'b1;
				if (!seen && (next_q != NEXT_MAX)) begin
					next_q <= next_q + NEXT_BITS'(1);
				end
			end

			if (advance) begin
				valid_s1    <= accept;
				out_valid_q <= valid_s1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1   <= req.action;
			in_range_s1 <= (32'(req.node_index) < NODE_COUNT);
			addr_s1     <= AW'(req.node_index);
		end
		if (do_ref) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= ram_wdata;
		end
		if (advance && valid_s1) begin
			out_number_q <= res_number;
			out_rank_q   <= res_rank;
			out_fresh_q  <= res_fresh;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.new_number      = out_number_q;
	assign rsp.occurrence_rank = RANK_OUT_BITS'(out_rank_q);
	assign rsp.newly_assigned  = out_fresh_q;

	// No item enters while the clearing pass owns the RAM
	assert property (@(posedge clk) disable iff (!arst_n)
		pass_q |-> !(req.valid && req.ready))
		else $error("item accepted during clearing pass");

	// The counter only moves back on a clear
	assert property (@(posedge clk) disable iff (!arst_n)
		!do_clear |=> (next_q >= $past(next_q)))
		else $error("next number went back without a clear");

	// A fresh assignment always reports no prior references
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.newly_assigned) |-> (rsp.occurrence_rank == '0))
		else $error("fresh node reported a nonzero rank");

	// Write-back never collides with the clearing pass
	assert property (@(posedge clk) disable iff (!arst_n)
		pass_q |-> !do_ref)
		else $error("write-back during clearing pass");

endmodule

[design/ftnr_ram.sv]
module ftnr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;

	import ftnr_pkg::*;

	localparam int NODE_COUNT = NODE_COUNT_DEF;
	localparam int RANK_BITS  = RANK_BITS_DEF;
	localparam logic [NEXT_BITS-1:0] NEXT_TOP = '1;
	localparam logic [RANK_BITS-1:0] RANK_TOP = '1;
	// No item is accepted during the clearing pass after reset and after a tag
	// wrap, which writes all NODE_COUNT words, so the limit sits well above it.
	localparam int STALL_LIMIT = 5 * NODE_COUNT;
	localparam int RANDOM_ITEMS = 600;
	localparam int IDLE_PCT = 36;

	typedef struct packed {
		logic [NUMBER_BITS-1:0]   new_number;
		logic [RANK_OUT_BITS-1:0] occurrence_rank;
		logic                     newly_assigned;
	} renum_result_t;

	typedef struct {
		action_t                act;
		logic [INDEX_BITS-1:0]  idx;
		bit                     typed;
		renum_result_t          res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	ftnr_req_if req_ch ();
	ftnr_rsp_if rsp_ch ();

	first_touch_node_renumbering_top #(
		.NODE_COUNT(NODE_COUNT),
		.RANK_BITS (RANK_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Renumbering map as the block should hold it
	bit                     node_seen [NODE_COUNT];
	logic [NUMBER_BITS-1:0] node_number [NODE_COUNT];
	logic [RANK_BITS-1:0]   node_rank [NODE_COUNT];
	logic [NEXT_BITS-1:0]   next_free_number;

	// Results still owed by the block, oldest first
	renum_result_t owed_results[$];
	stim_row_t     stim_rows[$];

	// Typed expectation travels with the item, registered like the payload
	bit            row_typed;
	renum_result_t row_result;

	int  errors;
	int  stall_cycles;
	bit  quiet;
	renum_result_t want;
	renum_result_t got;

	// Apply one item to the map and return the answer it earns.
	function automatic renum_result_t renumber_node(action_t act, logic [INDEX_BITS-1:0] idx);
		renum_result_t r;
		r = '0;
		if (act == ACT_CLEAR) begin
			// Numbers stay in place; only the seen flags, ranks and counter reset
			for (int k = 0; k < NODE_COUNT; k++) begin
				node_seen[k] = 1'b0;
				node_rank[k] = '0;
			end
			next_free_number = '0;
			return r;
		end
		if (int'(idx) >= NODE_COUNT)
			return r;
		if (!node_seen[idx]) begin
			node_seen[idx] = 1'b1;
			node_number[idx] = next_free_number[NUMBER_BITS-1:0];
			if (next_free_number != NEXT_TOP)
				next_free_number++;
			r.newly_assigned = 1'b1;
		end
		r.new_number = node_number[idx];
		r.occurrence_rank = RANK_OUT_BITS'(node_rank[idx]);
		// Saturate the rank at its top value
		if (node_rank[idx] != RANK_TOP)
			node_rank[idx]++;
		return r;
	endfunction

	function automatic void add_row(action_t act, logic [INDEX_BITS-1:0] idx, int typed,
		int num, int rank, int fresh);
		stim_row_t s;
		s.act = act;
		s.idx = idx;
		s.typed = (typed != 0);
		s.res.new_number = NUMBER_BITS'(num);
		s.res.occurrence_rank = RANK_OUT_BITS'(rank);
		s.res.newly_assigned = (fresh != 0);
		stim_rows.push_back(s);
	endfunction

	// Offer one request item, idling at random first outside the quiet stretch, and hold it until taken.
	task automatic send_item(action_t act, logic [INDEX_BITS-1:0] idx, bit typed,
		renum_result_t res);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.action     <= act;
		req_ch.node_index <= idx;
		row_typed         <= typed;
		row_result        <= res;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// Track both handshakes in one place so a request taken at an edge is
	// always queued before any response at the same edge is checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				got = renumber_node(req_ch.action, req_ch.node_index);
				// Directed rows with a typed answer use it instead
				owed_results.push_back(row_typed ? row_result : got);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (owed_results.size() == 0) begin
					$display("%0t: response with nothing owed: number %0d rank %0d new %0b",
						$time, rsp_ch.new_number, rsp_ch.occurrence_rank,
						rsp_ch.newly_assigned);
					errors++;
				end else begin
					want = owed_results.pop_front();
					if (rsp_ch.new_number !== want.new_number) begin
						$display("%0t: new_number expected %0d, actual %0d", $time,
							want.new_number, rsp_ch.new_number);
						errors++;
					end
					if (rsp_ch.occurrence_rank !== want.occurrence_rank) begin
						$display("%0t: occurrence_rank expected %0d, actual %0d", $time,
							want.occurrence_rank, rsp_ch.occurrence_rank);
						errors++;
					end
					if (rsp_ch.newly_assigned !== want.newly_assigned) begin
						$display("%0t: newly_assigned expected %0b, actual %0b", $time,
							want.newly_assigned, rsp_ch.newly_assigned);
						errors++;
					end
				end
			end
			// Stall the response side at random, except in the quiet stretch
			rsp_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		logic [INDEX_BITS-1:0] pool [8];
		logic [INDEX_BITS-1:0] base;
		logic [INDEX_BITS-1:0] idx;
		action_t act;
		int random_items;
		int mesh_no;
		int n_tetra;
		int pool_size;
		int hot_pct;
		int corners;
		int clears;
		int pick;
		bit big;

		// Drive every input to a known value before the first edge
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_REF;
		req_ch.node_index = '0;
		rsp_ch.ready = 1'b0;
		row_typed = 1'b0;
		row_result = '0;
		errors = 0;
		stall_cycles = 0;
		quiet = 1'b0;
		next_free_number = '0;
		for (int k = 0; k < NODE_COUNT; k++) begin
			node_seen[k] = 1'b0;
			node_number[k] = '0;
			node_rank[k] = '0;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: extremes of the index, repeats, clears, then two tetrahedra
		add_row(ACT_REF,   12'h000, 1, 0, 0, 1);
		add_row(ACT_REF,   12'hFFF, 1, 1, 0, 1);
		add_row(ACT_REF,   12'h000, 1, 0, 1, 0);
		add_row(ACT_REF,   12'hFFF, 1, 1, 1, 0);
		add_row(ACT_REF,   12'hAAA, 1, 2, 0, 1);
		add_row(ACT_REF,   12'h555, 1, 3, 0, 1);
		add_row(ACT_REF,   12'hAAA, 1, 2, 1, 0);
		add_row(ACT_REF,   12'h000, 1, 0, 2, 0);
		// A clear ignores its index and answers with zeros
		add_row(ACT_CLEAR, 12'hFFF, 1, 0, 0, 0);
		add_row(ACT_REF,   12'h555, 1, 0, 0, 1);
		// Back-to-back clears
		add_row(ACT_CLEAR, 12'h000, 1, 0, 0, 0);
		add_row(ACT_CLEAR, 12'hAAA, 1, 0, 0, 0);
		// Same node in a row exercises the write-back forwarding
		add_row(ACT_REF,   12'hFFF, 1, 0, 0, 1);
		add_row(ACT_REF,   12'hFFF, 1, 0, 1, 0);
		add_row(ACT_REF,   12'hFFF, 1, 0, 2, 0);
		add_row(ACT_REF,   12'h000, 1, 1, 0, 1);
		add_row(ACT_REF,   12'd100, 0, 0, 0, 0);
		add_row(ACT_REF,   12'd101, 0, 0, 0, 0);
		add_row(ACT_REF,   12'd102, 0, 0, 0, 0);
		add_row(ACT_REF,   12'd103, 0, 0, 0, 0);
		add_row(ACT_REF,   12'd104, 0, 0, 0, 0);
		add_row(ACT_REF,   12'd100, 0, 0, 0, 0);
		add_row(ACT_REF,   12'd101, 0, 0, 0, 0);
		add_row(ACT_REF,   12'd105, 0, 0, 0, 0);

		foreach (stim_rows[i])
			send_item(stim_rows[i].act, stim_rows[i].idx, stim_rows[i].typed,
				stim_rows[i].res);

		// Random part: meshes of tetrahedra that touch a few hot nodes and a
		// local window, with broken tetrahedra and stray items mixed in; each
		// mesh ends with one or more clears.
		random_items = 0;
		mesh_no = 0;
		while (random_items < RANDOM_ITEMS) begin
			// One long mesh runs with no idling; one hammers a single node to saturate it
			quiet = (mesh_no == 1);
			big = (mesh_no == 2);
			n_tetra = big ? 90 : (quiet ? 30 : $urandom_range(2, 20));
			pool_size = big ? 1 : $urandom_range(1, 8);
			hot_pct = big ? 95 : $urandom_range(0, 80);
			base = INDEX_BITS'($urandom_range(0, NODE_COUNT - 64));
			for (int p = 0; p < 8; p++)
				pool[p] = base + INDEX_BITS'($urandom_range(0, 63));
			for (int t = 0; t < n_tetra; t++) begin
				corners = ($urandom_range(99) < 8) ? $urandom_range(1, 3) : 4;
				for (int c = 0; c < corners; c++) begin
					pick = $urandom_range(99);
					if (pick < hot_pct)
						idx = pool[$urandom_range(0, pool_size - 1)];
					else if (pick < 95)
						idx = base + INDEX_BITS'($urandom_range(0, 63));
					else
						idx = INDEX_BITS'($urandom_range(0, NODE_COUNT - 1));
					send_item(ACT_REF, idx, 1'b0, '0);
					random_items++;
				end
				// Stray item anywhere, now and then a clear in mid-mesh
				if ($urandom_range(99) < 5) begin
					act = ($urandom_range(3) == 0) ? ACT_CLEAR : ACT_REF;
					send_item(act, INDEX_BITS'($urandom_range(0, NODE_COUNT - 1)), 1'b0, '0);
					random_items++;
				end
			end
			clears = ($urandom_range(99) < 25) ? $urandom_range(2, 3) : 1;
			for (int c = 0; c < clears; c++) begin
				send_item(ACT_CLEAR, INDEX_BITS'($urandom_range(0, NODE_COUNT - 1)),
					1'b0, '0);
				random_items++;
			end
			mesh_no++;
		end
		quiet = 1'b0;
		req_ch.valid <= 1'b0;

		// Drain what is owed, then give the pipeline time to show strays
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[first_touch_node_renumbering_top.f]
design/ftnr_pkg.sv
design/ftnr_req_if.sv
design/ftnr_rsp_if.sv
design/ftnr_ram.sv
design/first_touch_node_renumbering_top.sv
sim/testbench.sv
